// File: sv/blma_pkg.sv
package blma_pkg;

  localparam int LEVEL_W  = 12;
  localparam int GAIN_W   = 24;
  localparam int PCT_W    = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = GAIN_W;

  localparam int WINDOW_DEF = 20;

  localparam logic [LEVEL_W-1:0] EMPTY_LEVEL_RST  = LEVEL_W'(2358);
  localparam logic [GAIN_W-1:0]  PERCENT_GAIN_RST = GAIN_W'(56334);
  localparam logic [PCT_W-1:0]   FULL_PCT         = PCT_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMPTY_LEVEL  = 1'b0,
    CFG_PERCENT_GAIN = 1'b1
  } cfg_idx_e;

  // One step of the sample window.
  typedef struct packed {
    logic               load;
    logic [LEVEL_W-1:0] sample;
  } win_step_t;

  function automatic int sum_width(input int window);
    sum_width = $clog2(window * 4095 + 1);
  endfunction

endpackage

// File: sv/blma_window.sv
module blma_window
  import blma_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int SUM_W  = sum_width(WINDOW)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  win_step_t        step_i,
  output logic [SUM_W-1:0] sum_o
);

  logic [LEVEL_W-1:0] line_q [WINDOW];
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               primed_q;

  // first sample seeds every tap, so the sum is just WINDOW * sample
  always_comb begin
    if (primed_q) begin
      sum_d = sum_q - SUM_W'(line_q[WINDOW-1]) + SUM_W'(step_i.sample);
    end else begin
      sum_d = SUM_W'(step_i.sample) * SUM_W'(WINDOW);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      primed_q <= 1'b0;
    end else if (step_i.load) begin
      sum_q    <= sum_d;
      primed_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.load) begin
      line_q[0] <= step_i.sample;
      for (int i = 1; i < WINDOW; i++) begin
        line_q[i] <= primed_q ? line_q[i-1] : step_i.sample;
      end
    end
  end

  assign sum_o = sum_q;

endmodule

// File: sv/battery_level_moving_average_top.sv
// Throughput: one sample per cycle while the result side does not stall;
// four pipeline stages (input, window sum, multiply, output) each fill a
// bubble while the result side stalls.
// Reset: valid bits, window sum and primed flag clear; registers take their
// defaults (empty level 2358, gain 56334). The window taps need no reset.
module battery_level_moving_average_top
  import blma_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample channel
  input  logic                  sample_valid_i,
  output logic                  sample_stall_o,
  input  logic [LEVEL_W-1:0]    sample_i,
  // result channel
  output logic                  result_valid_o,
  input  logic                  result_stall_i,
  output logic [PCT_W-1:0]      charge_percent_o,
  output logic [LEVEL_W-1:0]    average_level_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SUM_W   = sum_width(WINDOW);
  // floor(sum / WINDOW) as (sum * RECIP) >> SHIFT, exact for any SUM_W-bit sum
  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int PROD_W  = SUM_W + GAIN_W;

  // ---------------------------------------------------------------------
  // Configuration. The empty level is kept pre-scaled by WINDOW so the
  // datapath compares it straight against the window sum.
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0]  floor_q;
  logic [GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= SUM_W'(EMPTY_LEVEL_RST) * SUM_W'(WINDOW);
      gain_q  <= PERCENT_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_EMPTY_LEVEL:  floor_q <= SUM_W'(cfg_data_i[LEVEL_W-1:0]) * SUM_W'(WINDOW);
        CFG_PERCENT_GAIN: gain_q  <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage takes a new beat when it is empty or
  // its content moves on in the same cycle.
  // ---------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, vo_q;
  logic rdy0, rdy1, rdy2, rdy3;

  always_comb begin
    rdy3 = !vo_q || !result_stall_i;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    rdy0 = !v0_q || rdy1;
  end

  assign sample_stall_o = !rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= sample_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) vo_q <= v2_q;
    end
  end

  // Stage 0: input register
  logic [LEVEL_W-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (rdy0 && sample_valid_i) sample_q <= sample_i;
  end

  // Stage 1: window update; the running sum register is this stage's data
  win_step_t        step;
  logic [SUM_W-1:0] sum;

  assign step.load   = v0_q && rdy1;
  assign step.sample = sample_q;

  blma_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .sum_o  (sum)
  );

  // Stage 2: gain multiply and reciprocal multiply, side by side
  logic [SUM_W-1:0]         diff;
  logic [PROD_W-1:0]        prod_q;
  logic                     above_q;
  logic [SUM_W+RECIP_W-1:0] quot;
  logic [LEVEL_W-1:0]       avg_q;

  assign diff = sum - floor_q;
  assign quot = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP);

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      above_q <= sum > floor_q;
      prod_q  <= PROD_W'(diff) * PROD_W'(gain_q);
      avg_q   <= quot[SHIFT +: LEVEL_W];
    end
  end

  // Stage 3: drop the Q0.24 fraction, zero at or below empty, clamp at full, output register
  logic [SUM_W-1:0] scaled;
  logic [PCT_W-1:0] pct;

  assign scaled = prod_q[GAIN_W +: SUM_W];

  always_comb begin
    if (!above_q) begin
      pct = '0;
    end else if (scaled > SUM_W'(FULL_PCT)) begin
      pct = FULL_PCT;
    end else begin
      pct = scaled[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      charge_percent_o <= pct;
      average_level_o  <= avg_q;
    end
  end

  assign result_valid_o = vo_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && vo_q && result_stall_i |=> v2_q && vo_q)
    else $error("beat lost while output stalled");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v0_q |-> !sample_stall_o)
    else $error("empty input stage stalls");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> charge_percent_o <= FULL_PCT)
    else $error("charge above full");

endmodule
